// ===== rtl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
// no dependencies; define ASSERT_OFF to drop every check
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/tvcf_pkg.sv =====
// shared types and constants of the thermal and visible color fusion block
// no dependencies
package tvcf_pkg;

  localparam int COORD_BITS  = 16;
  localparam int QW          = 8;
  localparam int DIV_STAGES  = QW;
  localparam int DIV_DW      = 16;
  localparam int DIV_NW      = (COORD_BITS + 8 > 24) ? COORD_BITS + 8 : 24;
  localparam int LANES       = 4;
  localparam int LUMA_STAGES = 3;
  localparam int PAL_DEPTH   = 256;
  localparam int PAL_AW      = 8;
  localparam int RGB_W       = 24;

  localparam logic REQ_PALETTE = 1'b0;
  localparam logic REQ_POINT   = 1'b1;

  typedef enum logic [2:0] {
    REG_MIN_TEMP  = 3'd0,
    REG_MAX_TEMP  = 3'd1,
    REG_CONF_THR  = 3'd2,
    REG_CLAMP     = 3'd3,
    REG_DEAD_MODE = 3'd4,
    REG_VOL_SIZE  = 3'd5,
    REG_FUS_LOWER = 3'd6,
    REG_FUS_UPPER = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    DEAD_KEEP = 2'd0,
    DEAD_GRAY = 2'd1,
    DEAD_POS  = 2'd2,
    DEAD_RSV  = 2'd3
  } dead_mode_e;

  typedef struct packed {
    logic [15:0] min_t;
    logic [15:0] max_t;
    logic [7:0]  thr;
    logic        clamp;
    dead_mode_e  mode;
    logic [14:0] vsize;
    logic [8:0]  f_lo;
    logic [8:0]  f_hi;
  } cfg_t;

  typedef struct packed {
    logic [DIV_NW-1:0] n;
    logic [DIV_DW-1:0] d;
  } div_in_t;

  typedef struct packed {
    logic             pt;
    logic             tv;
    logic             vv;
    logic [PAL_AW-1:0] pidx;
    logic [RGB_W-1:0] pcol;
    logic [RGB_W-1:0] vis;
    logic [RGB_W-1:0] prior;
    logic [2:0]       sat;
  } side_t;

  typedef struct packed {
    logic               pt;
    logic               tv;
    logic               vv;
    logic [RGB_W-1:0]   vis;
    logic [RGB_W-1:0]   prior;
    logic [RGB_W-1:0]   axis;
    logic signed [9:0]  lum;
  } post_t;

endpackage

// ===== rtl/tvcf_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module tvcf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/tvcf_front.sv =====
// first stage: validity, clamping, divider operands and luma sum
// depends on tvcf_pkg
module tvcf_front import tvcf_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  cfg_t                         cfg_i,
  input  logic                         valid_i,
  input  logic                         req_type_i,
  input  logic [7:0]                   palette_index_i,
  input  logic [23:0]                  palette_color_i,
  input  logic [23:0]                  visible_rgb_i,
  input  logic [15:0]                  thermal_raw_i,
  input  logic [7:0]                   confidence_i,
  input  logic signed [COORD_BITS-1:0] pos_x_i,
  input  logic signed [COORD_BITS-1:0] pos_y_i,
  input  logic signed [COORD_BITS-1:0] pos_z_i,
  input  logic [23:0]                  prior_rgb_i,
  output logic                         valid_o,
  output side_t                        side_o,
  output div_in_t                      div_o [LANES],
  output logic [15:0]                  ysum_o
);

  logic                         valid_q;
  side_t                        side_d, side_q;
  div_in_t                      div_d [LANES];
  div_in_t                      div_q [LANES];
  logic [15:0]                  ysum_d, ysum_q;
  logic signed [COORD_BITS-1:0] pos [3];

  assign pos[0] = pos_x_i;
  assign pos[1] = pos_y_i;
  assign pos[2] = pos_z_i;

  always_comb begin
    logic              empty;
    logic [15:0]       tc;
    logic [15:0]       dt;
    logic [DIV_DW-1:0] dv;
    logic [DIV_NW-1:0] pe;
    logic [DIV_NW-1:0] n255;
    logic [DIV_NW-1:0] dsh;
    logic              pos_p;
    logic              sat;
    empty = !(cfg_i.max_t > cfg_i.min_t);
    if (thermal_raw_i > cfg_i.max_t) begin
      tc = cfg_i.max_t;
    end else if (thermal_raw_i < cfg_i.min_t) begin
      tc = cfg_i.min_t;
    end else begin
      tc = thermal_raw_i;
    end
    dt = tc - cfg_i.min_t;
    div_d[0].n = empty ? '0 : DIV_NW'({dt, 8'b0} - {8'b0, dt});
    div_d[0].d = empty ? DIV_DW'(1) : cfg_i.max_t - cfg_i.min_t;

    dv = (cfg_i.vsize == '0) ? DIV_DW'(1) : DIV_DW'(cfg_i.vsize);
    dsh = DIV_NW'(dv) << 8;
    side_d.sat = '0;
    for (int k = 0; k < 3; k++) begin
      pos_p = !pos[k][COORD_BITS-1] && (pos[k] != '0);
      pe = DIV_NW'($unsigned(pos[k]));
      n255 = (pe << 8) - pe;
      sat = pos_p && (n255 >= dsh);
      side_d.sat[k] = sat;
      div_d[k+1].n = (pos_p && !sat) ? n255 : '0;
      div_d[k+1].d = dv;
    end

    side_d.pt    = (req_type_i == REQ_POINT);
    side_d.vv    = (visible_rgb_i != '0);
    side_d.tv    = (confidence_i >= cfg_i.thr) &&
                   (cfg_i.clamp || (thermal_raw_i >= cfg_i.min_t &&
                                    thermal_raw_i <= cfg_i.max_t));
    side_d.pidx  = palette_index_i;
    side_d.pcol  = palette_color_i;
    side_d.vis   = visible_rgb_i;
    side_d.prior = prior_rgb_i;

    ysum_d = 16'(visible_rgb_i[23:16]) * 16'd77 + 16'(visible_rgb_i[15:8]) * 16'd150 +
             16'(visible_rgb_i[7:0]) * 16'd29;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_d;
      ysum_q <= ysum_d;
      div_q  <= div_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign div_o   = div_q;
  assign ysum_o  = ysum_q;

endmodule

// ===== rtl/tvcf_div.sv =====
// pipelined restoring divider, one quotient bit per stage, four lanes
// depends on tvcf_pkg
module tvcf_div import tvcf_pkg::*; (
  input  logic          clk_i,
  input  logic          en_i,
  input  div_in_t       div_i [LANES],
  output logic [QW-1:0] q_o [LANES]
);

  div_in_t       st_d [DIV_STAGES][LANES];
  div_in_t       st_q [DIV_STAGES][LANES];
  logic [QW-1:0] q_d  [DIV_STAGES][LANES];
  logic [QW-1:0] q_q  [DIV_STAGES][LANES];

  always_comb begin
    div_in_t           src;
    logic [QW-1:0]     qs;
    logic [DIV_NW-1:0] cmp;
    logic              ge;
    for (int s = 0; s < DIV_STAGES; s++) begin
      for (int l = 0; l < LANES; l++) begin
        if (s == 0) begin
          src = div_i[l];
          qs  = '0;
        end else begin
          src = st_q[s-1][l];
          qs  = q_q[s-1][l];
        end
        cmp = DIV_NW'(src.d) << (QW - 1 - s);
        ge  = (src.n >= cmp);
        st_d[s][l].n = ge ? src.n - cmp : src.n;
        st_d[s][l].d = src.d;
        qs[QW-1-s]   = ge;
        q_d[s][l]    = qs;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
      q_q  <= q_d;
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      q_o[l] = q_q[DIV_STAGES-1][l];
    end
  end

endmodule

// ===== rtl/tvcf_luma.sv =====
// signed luma factor from the visible sum, aligned to the divider latency
// depends on tvcf_pkg
module tvcf_luma import tvcf_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [15:0]       ysum_i,
  input  logic signed [9:0] diff_i,
  output logic signed [9:0] lum_o
);

  localparam int DLY = DIV_STAGES - LUMA_STAGES + 1;

  logic signed [25:0] prod_d, prod_q;
  logic [15:0]        m_d, m_q;
  logic [8:0]         q0_d, q0_q;
  logic               neg_d, neg_q;
  logic signed [9:0]  lum_d;
  logic signed [9:0]  lum_q [DLY];

  always_comb begin
    logic signed [18:0] x;
    logic [23:0]        a;
    logic [24:0]        t257;
    logic [16:0]        q255;
    logic [16:0]        r;
    logic [8:0]         q;
    x      = $signed({2'b0, ysum_i, 1'b0}) - 19'sd65280;
    prod_d = 26'(x) * 26'(diff_i);

    neg_d = prod_q[25];
    a     = 24'(neg_d ? -prod_q : prod_q);
    m_d   = a[23:8];
    t257  = {1'b0, m_d, 8'b0} + 25'(m_d);
    q0_d  = t257[24:16];

    q255  = {q0_q, 8'b0} - 17'(q0_q);
    r     = 17'(m_q) - q255;
    q     = q0_q + 9'(r >= 17'd255);
    lum_d = neg_q ? -$signed({1'b0, q}) : $signed({1'b0, q});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q   <= prod_d;
      m_q      <= m_d;
      q0_q     <= q0_d;
      neg_q    <= neg_d;
      lum_q[0] <= lum_d;
      for (int k = 1; k < DLY; k++) begin
        lum_q[k] <= lum_q[k-1];
      end
    end
  end

  assign lum_o = lum_q[DLY-1];

endmodule

// ===== rtl/tvcf_shade.sv =====
// palette shading by luma and final color selection, two stages to the output
// depends on tvcf_pkg
module tvcf_shade import tvcf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  dead_mode_e       mode_i,
  input  logic             valid_i,
  input  post_t            post_i,
  input  logic [RGB_W-1:0] pc_i,
  output logic             valid_o,
  output logic [RGB_W-1:0] rgb_o,
  output logic [1:0]       class_o
);

  logic               v1_q;
  post_t              p1_q;
  logic [RGB_W-1:0]   pc1_q;
  logic signed [18:0] m_d [3];
  logic signed [18:0] m_q [3];
  logic               vo_q;
  logic [RGB_W-1:0]   rgb_d, rgb_q;
  logic [1:0]         cls_q;

  always_comb begin
    logic [7:0]        c;
    logic signed [9:0] f;
    for (int ch = 0; ch < 3; ch++) begin
      c = pc_i[8*ch +: 8];
      f = (post_i.lum > 0) ? $signed({2'b0, 8'd255 - c}) : $signed({2'b0, c});
      m_d[ch] = 19'(f) * 19'(post_i.lum);
    end
  end

  always_comb begin
    logic [7:0]         c;
    logic signed [19:0] v;
    logic [RGB_W-1:0]   fused;
    for (int ch = 0; ch < 3; ch++) begin
      c = pc1_q[8*ch +: 8];
      v = $signed({4'b0, c, 8'b0}) + 20'(m_q[ch]);
      if (v[19]) begin
        fused[8*ch +: 8] = '0;
      end else if (|v[19:16]) begin
        fused[8*ch +: 8] = 8'hff;
      end else begin
        fused[8*ch +: 8] = v[15:8];
      end
    end
    if (p1_q.tv && p1_q.vv) begin
      rgb_d = fused;
    end else if (p1_q.tv) begin
      rgb_d = pc1_q;
    end else if (p1_q.vv) begin
      rgb_d = p1_q.vis;
    end else if (mode_i == DEAD_GRAY) begin
      rgb_d = 24'h808080;
    end else if (mode_i == DEAD_POS) begin
      rgb_d = p1_q.axis;
    end else begin
      rgb_d = p1_q.prior;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i && post_i.pt;
      vo_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q  <= post_i;
      pc1_q <= pc_i;
      m_q   <= m_d;
      rgb_q <= rgb_d;
      cls_q <= {p1_q.tv, p1_q.vv};
    end
  end

  assign valid_o = vo_q;
  assign rgb_o   = rgb_q;
  assign class_o = cls_q;

endmodule

// ===== rtl/thermal_visible_color_fusion.sv =====
// Each accepted word is either a palette write or one point; a point gives one output word
// and a new word can enter every cycle while in_stall_o is low. A point passes through the
// 8-stage quotient divider that turns temperature and position into palette index and
// axis color, followed by the palette ram read and two shading stages. Palette writes take
// effect at the ram stage, in order with the points around them, and give no output word.
// in_stall_o rises only while a finished word waits on out_stall_i; the whole pipeline then
// holds. The user writes configuration only while the block is empty; nothing enforces it.
// top level; depends on assert_macros.svh, tvcf_pkg, tvcf_front, tvcf_div, tvcf_luma, tvcf_ram, tvcf_shade
`include "assert_macros.svh"
module thermal_visible_color_fusion import tvcf_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [2:0]                   cfg_idx_i,
  input  logic [15:0]                  cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         req_type_i,
  input  logic [7:0]                   palette_index_i,
  input  logic [23:0]                  palette_color_i,
  input  logic [23:0]                  visible_rgb_i,
  input  logic [15:0]                  thermal_raw_i,
  input  logic [7:0]                   confidence_i,
  input  logic signed [COORD_BITS-1:0] pos_x_i,
  input  logic signed [COORD_BITS-1:0] pos_y_i,
  input  logic signed [COORD_BITS-1:0] pos_z_i,
  input  logic [23:0]                  prior_rgb_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [23:0]                  out_rgb_o,
  output logic [1:0]                   point_class_o
);

  cfg_t              cfg_q;
  logic              en;
  logic              vf;
  side_t             side_f;
  div_in_t           div_f [LANES];
  logic [15:0]       ysum_f;
  logic [QW-1:0]     quo [LANES];
  logic signed [9:0] diff;
  logic signed [9:0] lum;
  logic              vd_q [DIV_STAGES];
  side_t             sd_q [DIV_STAGES];
  logic              vp_q;
  post_t             post_d, post_q;
  logic [RGB_W-1:0]  pc;
  logic              ram_we;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_t <= 16'd1000;
      cfg_q.max_t <= 16'd2000;
      cfg_q.thr   <= '0;
      cfg_q.clamp <= 1'b0;
      cfg_q.mode  <= DEAD_GRAY;
      cfg_q.vsize <= 15'd4096;
      cfg_q.f_lo  <= '0;
      cfg_q.f_hi  <= 9'd128;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_MIN_TEMP:  cfg_q.min_t <= cfg_wdata_i;
        REG_MAX_TEMP:  cfg_q.max_t <= cfg_wdata_i;
        REG_CONF_THR:  cfg_q.thr   <= cfg_wdata_i[7:0];
        REG_CLAMP:     cfg_q.clamp <= cfg_wdata_i[0];
        REG_DEAD_MODE: cfg_q.mode  <= dead_mode_e'(cfg_wdata_i[1:0]);
        REG_VOL_SIZE:  cfg_q.vsize <= cfg_wdata_i[14:0];
        REG_FUS_LOWER: cfg_q.f_lo  <= cfg_wdata_i[8:0];
        REG_FUS_UPPER: cfg_q.f_hi  <= cfg_wdata_i[8:0];
        default:       cfg_q.f_hi  <= cfg_q.f_hi;
      endcase
    end
  end

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;
  assign diff       = $signed({1'b0, cfg_q.f_hi}) - $signed({1'b0, cfg_q.f_lo});

  tvcf_front u_front (
    .clk_i,
    .rst_ni,
    .en_i    (en),
    .cfg_i   (cfg_q),
    .valid_i (in_valid_i),
    .req_type_i,
    .palette_index_i,
    .palette_color_i,
    .visible_rgb_i,
    .thermal_raw_i,
    .confidence_i,
    .pos_x_i,
    .pos_y_i,
    .pos_z_i,
    .prior_rgb_i,
    .valid_o (vf),
    .side_o  (side_f),
    .div_o   (div_f),
    .ysum_o  (ysum_f)
  );

  tvcf_div u_div (
    .clk_i,
    .en_i  (en),
    .div_i (div_f),
    .q_o   (quo)
  );

  tvcf_luma u_luma (
    .clk_i,
    .en_i   (en),
    .ysum_i (ysum_f),
    .diff_i (diff),
    .lum_o  (lum)
  );

  // sideband that travels alongside the divider
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        vd_q[s] <= 1'b0;
      end
      vp_q <= 1'b0;
    end else if (en) begin
      vd_q[0] <= vf;
      for (int s = 1; s < DIV_STAGES; s++) begin
        vd_q[s] <= vd_q[s-1];
      end
      vp_q <= vd_q[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0] <= side_f;
      for (int s = 1; s < DIV_STAGES; s++) begin
        sd_q[s] <= sd_q[s-1];
      end
      post_q <= post_d;
    end
  end

  always_comb begin
    side_t sl;
    sl           = sd_q[DIV_STAGES-1];
    post_d.pt    = sl.pt;
    post_d.tv    = sl.tv;
    post_d.vv    = sl.vv;
    post_d.vis   = sl.vis;
    post_d.prior = sl.prior;
    post_d.lum   = lum;
    for (int k = 0; k < 3; k++) begin
      post_d.axis[8*(2-k) +: 8] = sl.sat[k] ? 8'hff : quo[k+1];
    end
  end

  assign ram_we = en && vd_q[DIV_STAGES-1] && (sd_q[DIV_STAGES-1].pt == REQ_PALETTE);

  tvcf_ram #(
    .WIDTH (RGB_W),
    .DEPTH (PAL_DEPTH)
  ) u_palette (
    .clk_i,
    .we_i    (ram_we),
    .waddr_i (sd_q[DIV_STAGES-1].pidx),
    .wdata_i (sd_q[DIV_STAGES-1].pcol),
    .re_i    (en),
    .raddr_i (quo[0]),
    .rdata_o (pc)
  );

  tvcf_shade u_shade (
    .clk_i,
    .rst_ni,
    .en_i    (en),
    .mode_i  (cfg_q.mode),
    .valid_i (vp_q),
    .post_i  (post_q),
    .pc_i    (pc),
    .valid_o (out_valid_o),
    .rgb_o   (out_rgb_o),
    .class_o (point_class_o)
  );

  `ASSERT_IMPLIES(a_stall_only_when_held, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i, "input stalled without a held word")
  `ASSERT_NEVER(a_write_is_not_point, clk_i, rst_ni, ram_we && sd_q[DIV_STAGES-1].pt, "palette written by a point")
  `ASSERT_IMPLIES(a_dead_gray, clk_i, rst_ni, out_valid_o && !(|point_class_o) && cfg_q.mode == DEAD_GRAY, out_rgb_o == 24'h808080, "dead point not gray")

endmodule

// ===== tb/thermal_visible_color_fusion_tb.sv =====
// testbench for thermal_visible_color_fusion: directed and random points and palette words
// checked against a built-in predictor of the fusion math; depends on tvcf_pkg and the rtl
`timescale 1ns / 1ps
module thermal_visible_color_fusion_tb;
  import tvcf_pkg::*;

  typedef struct {
    bit              req;
    bit [7:0]        pidx;
    bit [23:0]       pcol;
    bit [23:0]       vis;
    bit [15:0]       therm;
    bit [7:0]        conf;
    bit signed [15:0] px, py, pz;
    bit [23:0]       prior;
  } fusion_word_t;

  typedef struct {
    bit [23:0] rgb;
    bit [1:0]  cls;
  } color_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [15:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic req_type_i = REQ_POINT;
  logic [7:0] palette_index_i = '0;
  logic [23:0] palette_color_i = '0;
  logic [23:0] visible_rgb_i = '0;
  logic [15:0] thermal_raw_i = '0;
  logic [7:0] confidence_i = '0;
  logic signed [COORD_BITS-1:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic [23:0] prior_rgb_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [23:0] out_rgb_o;
  logic [1:0] point_class_o;

  thermal_visible_color_fusion dut (.*);

  cfg_t cur;
  bit [23:0] pal_model [256];
  color_t pending_colors [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;
  bit hold_used = 1'b0;
  int hold_cycles = 0;
  int cycles = 0;

  initial forever #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 300000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver stalls, with a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1'b1;
    end else if (hold_req && !hold_used) begin
      hold_used <= 1'b1;
      hold_cycles <= 79;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    color_t exp_c;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_colors.size() == 0) begin
        $display("%0t: unexpected word rgb=%h class=%0d", $time, out_rgb_o, point_class_o);
        errors++;
      end else begin
        exp_c = pending_colors.pop_front();
        if (out_rgb_o !== exp_c.rgb) begin
          $display("%0t: out_rgb expected %h actual %h", $time, exp_c.rgb, out_rgb_o);
          errors++;
        end
        if (point_class_o !== exp_c.cls) begin
          $display("%0t: point_class expected %0d actual %0d", $time, exp_c.cls,
                   point_class_o);
          errors++;
        end
      end
    end
  end

  function automatic bit [7:0] axis_channel(bit signed [15:0] p);
    int vs;
    int v;
    vs = (cur.vsize == 0) ? 1 : int'(cur.vsize);
    v = (255 * int'(p)) / vs;
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  function automatic bit [7:0] shade_channel(int c, int lum);
    int v;
    v = (lum > 0) ? c * 256 + (255 - c) * lum : c * 256 + c * lum;
    if (v < 0) return 8'd0;
    v = v >>> 8;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic color_t fuse_point(fusion_word_t w);
    color_t r;
    bit vv, tv;
    int unsigned tc, idx;
    int ysum, lum;
    bit [23:0] pc;
    vv = (w.vis != 0);
    tv = (w.conf >= cur.thr) &&
         (cur.clamp || (w.therm >= cur.min_t && w.therm <= cur.max_t));
    idx = 0;
    if (cur.max_t > cur.min_t) begin
      tc = 32'(w.therm);
      if (tc > 32'(cur.max_t)) tc = 32'(cur.max_t);
      if (tc < 32'(cur.min_t)) tc = 32'(cur.min_t);
      idx = (255 * (tc - 32'(cur.min_t))) / 32'(cur.max_t - cur.min_t);
      if (idx > 255) idx = 255;
    end
    pc = pal_model[idx];
    if (tv && vv) begin
      ysum = 77 * w.vis[23:16] + 150 * w.vis[15:8] + 29 * w.vis[7:0];
      lum = ((2 * ysum - 65280) * (int'(cur.f_hi) - int'(cur.f_lo))) / 65280;
      r.rgb = {shade_channel(int'(pc[23:16]), lum), shade_channel(int'(pc[15:8]), lum),
               shade_channel(int'(pc[7:0]), lum)};
    end else if (tv) begin
      r.rgb = pc;
    end else if (vv) begin
      r.rgb = w.vis;
    end else if (cur.mode == DEAD_GRAY) begin
      r.rgb = 24'h808080;
    end else if (cur.mode == DEAD_POS) begin
      r.rgb = {axis_channel(w.px), axis_channel(w.py), axis_channel(w.pz)};
    end else begin
      r.rgb = w.prior;
    end
    r.cls = {tv, vv};
    return r;
  endfunction

  task automatic send_word(fusion_word_t w);
    req_type_i <= w.req;
    palette_index_i <= w.pidx;
    palette_color_i <= w.pcol;
    visible_rgb_i <= w.vis;
    thermal_raw_i <= w.therm;
    confidence_i <= w.conf;
    pos_x_i <= w.px;
    pos_y_i <= w.py;
    pos_z_i <= w.pz;
    prior_rgb_i <= w.prior;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    if (w.req == REQ_PALETTE) pal_model[w.pidx] = w.pcol;
    else pending_colors.push_back(fuse_point(w));
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  function automatic bit [15:0] reg_value(cfg_reg_e r);
    case (r)
      REG_MIN_TEMP:  return cur.min_t;
      REG_MAX_TEMP:  return cur.max_t;
      REG_CONF_THR:  return 16'(cur.thr);
      REG_CLAMP:     return 16'(cur.clamp);
      REG_DEAD_MODE: return 16'(cur.mode);
      REG_VOL_SIZE:  return 16'(cur.vsize);
      REG_FUS_LOWER: return 16'(cur.f_lo);
      default:       return 16'(cur.f_hi);
    endcase
  endfunction

  task automatic apply_config(cfg_t c);
    cfg_reg_e r;
    drain();
    cur = c;
    r = r.first();
    do begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= r;
      cfg_wdata_i <= reg_value(r);
      @(posedge clk_i);
      r = r.next();
    end while (r != r.first());
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic fusion_word_t palette_word(bit [7:0] i, bit [23:0] c);
    fusion_word_t w;
    w = '{default: '0};
    w.req = REQ_PALETTE;
    w.pidx = i;
    w.pcol = c;
    w.vis = 24'($urandom());
    w.therm = 16'($urandom());
    return w;
  endfunction

  function automatic bit signed [15:0] rand_coord();
    case ($urandom_range(4))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'(int'($urandom_range(8000)) - 4000);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic fusion_word_t rand_point();
    fusion_word_t w;
    w.req = REQ_POINT;
    w.pidx = 8'($urandom());
    w.pcol = 24'($urandom());
    w.vis = ($urandom_range(9) == 0) ? 24'h0 : 24'($urandom());
    if ($urandom_range(9) < 6 && cur.max_t >= cur.min_t)
      w.therm = 16'($urandom_range(cur.max_t, cur.min_t));
    else
      w.therm = 16'($urandom());
    w.conf = 8'($urandom());
    w.px = rand_coord();
    w.py = rand_coord();
    w.pz = rand_coord();
    w.prior = 24'($urandom());
    return w;
  endfunction

  task automatic run_random(int n);
    repeat (n) begin
      if ($urandom_range(19) == 0) send_word(palette_word(8'($urandom()), 24'($urandom())));
      else send_word(rand_point());
    end
  endtask

  task automatic test_palette_load();
    for (int i = 0; i < 256; i++) send_word(palette_word(i[7:0], 24'($urandom())));
  endtask

  task automatic test_directed();
    fusion_word_t w;
    bit [15:0] temps [6] = '{16'd1000, 16'd2000, 16'd999, 16'd2001, 16'd0, 16'hffff};
    bit [23:0] viss [3] = '{24'h0, 24'hffffff, 24'h000001};
    foreach (temps[i]) foreach (viss[j]) begin
      w = rand_point();
      w.therm = temps[i];
      w.vis = viss[j];
      w.conf = (j == 2) ? 8'd0 : 8'd255;
      send_word(w);
    end
    w = rand_point();
    w.vis = 24'h0;
    w.therm = 16'd0;
    send_word(w);
    send_word(palette_word(8'd255, 24'hffffff));
    send_word(palette_word(8'd0, 24'h000000));
  endtask

  task automatic test_config_sweep(int per_phase);
    cfg_t c;
    apply_config('{16'd0, 16'hffff, 8'd255, 1'b1, DEAD_POS, 15'd1, 9'd0, 9'd256});
    run_random(per_phase);
    apply_config('{16'd3000, 16'd3000, 8'd0, 1'b0, DEAD_KEEP, 15'h7fff, 9'd256, 9'd0});
    run_random(per_phase);
    apply_config('{16'hffff, 16'd0, 8'd128, 1'b1, DEAD_RSV, 15'd0, 9'd256, 9'd256});
    run_random(per_phase);
    repeat (3) begin
      c.min_t = 16'($urandom_range(3000));
      c.max_t = c.min_t + 16'($urandom_range(4000));
      c.thr = 8'($urandom());
      c.clamp = 1'($urandom());
      c.mode = dead_mode_e'($urandom_range(2));
      c.vsize = ($urandom_range(3) == 0) ? 15'($urandom_range(32767, 1))
                                          : 15'($urandom_range(4000, 1));
      c.f_lo = 9'($urandom_range(256));
      c.f_hi = 9'($urandom_range(256));
      apply_config(c);
      run_random(per_phase);
    end
  endtask

  task automatic test_backpressure();
    apply_config('{16'd1000, 16'd2000, 8'd40, 1'b0, DEAD_POS, 15'd4096, 9'd0, 9'd128});
    send_idle_pct = 0;
    hold_req = 1'b1;
    run_random(60);
    drain();
  endtask

  initial begin
    cur = '{16'd1000, 16'd2000, 8'd0, 1'b0, DEAD_GRAY, 15'd4096, 9'd0, 9'd128};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 10;
    recv_idle_pct = 73;
    test_palette_load();
    test_directed();
    run_random(150);
    test_config_sweep(70);
    send_idle_pct = 73;
    recv_idle_pct = 10;
    test_config_sweep(70);
    test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_config_sweep(70);
    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
